### design/rv32i_subset_execute_macros.svh
// Assertion helpers shared by the checkers of the execute block.
// All of them sample on clk and are disabled while rst is high.
`ifndef RV32I_SUBSET_EXECUTE_MACROS_SVH
`define RV32I_SUBSET_EXECUTE_MACROS_SVH

// Same-cycle implication.
`define RSE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RSE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/rse_pkg.sv
package rse_pkg;

  localparam int unsigned XLEN       = 32;
  localparam int unsigned NREGS      = 32;
  localparam int unsigned REG_AW     = $clog2(NREGS);
  localparam int unsigned DATA_DEPTH = 256;
  localparam int unsigned DATA_AW    = $clog2(DATA_DEPTH);
  localparam int unsigned PRE_AW     = 8;

  typedef logic [XLEN-1:0]    word_t;
  typedef logic [REG_AW-1:0]  reg_idx_t;
  typedef logic [DATA_AW-1:0] data_addr_t;

  localparam word_t PC_STEP    = word_t'(4);
  localparam word_t DATA_LIMIT = word_t'(DATA_DEPTH);

  // Command field codes
  localparam logic CMD_EXEC    = 1'b0;
  localparam logic CMD_PRELOAD = 1'b1;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_AND  = 4'd2,
    OP_OR   = 4'd3,
    OP_ADDI = 4'd4,
    OP_LW   = 4'd5,
    OP_SW   = 4'd6,
    OP_BEQ  = 4'd7,
    OP_BNE  = 4'd8,
    OP_JAL  = 4'd9,
    OP_NOP  = 4'd10
  } opcode_t;

  // Input item
  typedef struct packed {
    logic               command;
    logic [3:0]         opcode;
    reg_idx_t           dest_reg;
    reg_idx_t           src_reg_a;
    reg_idx_t           src_reg_b;
    logic signed [31:0] immediate;
    logic [PRE_AW-1:0]  preload_address;
    logic signed [31:0] preload_value;
  } in_t;

  // Result item
  typedef struct packed {
    word_t              next_pc;
    logic               reg_written;
    reg_idx_t           written_index;
    logic signed [31:0] written_value;
    logic               branch_taken;
    logic               address_fault;
  } out_t;

  // Register write-back port
  typedef struct packed {
    logic     en;
    reg_idx_t idx;
    word_t    value;
  } wb_t;

  // Data store access
  typedef struct packed {
    logic       wen;
    logic       ren;
    data_addr_t addr;
    word_t      wdata;
  } dmem_req_t;

endpackage

### design/rse_in_if.sv
interface rse_in_if;
  logic          valid;
  logic          ready;
  rse_pkg::in_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/rse_out_if.sv
interface rse_out_if;
  logic          valid;
  logic          ready;
  rse_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/rse_ram.sv
// Single write port, single registered read port; read returns old data
// when the same address is written at the same edge.
module rse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     ren,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/rse_regfile.sv
// 32 x 32 register file: two RAM copies give two read ports, valid bits
// make never-written registers (and x0) read as zero after reset.
module rse_regfile (
  input  logic              clk,
  input  logic              rst,
  input  rse_pkg::wb_t      wb,
  input  logic              ren,
  input  rse_pkg::reg_idx_t raddr_a,
  input  rse_pkg::reg_idx_t raddr_b,
  output rse_pkg::word_t    rdata_a,
  output rse_pkg::word_t    rdata_b
);

  logic [rse_pkg::NREGS-1:0] valid;
  logic                      valid_a;
  logic                      valid_b;
  rse_pkg::word_t            ram_a;
  rse_pkg::word_t            ram_b;

  rse_ram #(.WIDTH(rse_pkg::XLEN), .DEPTH(rse_pkg::NREGS)) u_ram_a (
    .clk   (clk),
    .wen   (wb.en),
    .waddr (wb.idx),
    .wdata (wb.value),
    .ren   (ren),
    .raddr (raddr_a),
    .rdata (ram_a)
  );

  rse_ram #(.WIDTH(rse_pkg::XLEN), .DEPTH(rse_pkg::NREGS)) u_ram_b (
    .clk   (clk),
    .wen   (wb.en),
    .waddr (wb.idx),
    .wdata (wb.value),
    .ren   (ren),
    .raddr (raddr_b),
    .rdata (ram_b)
  );

  // written-since-reset flags
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wb.en) begin
      valid[wb.idx] <= 1'b1;
    end
  end

  // flag read tracks the RAM read
  always_ff @(posedge clk) begin
    if (ren) begin
      valid_a <= valid[raddr_a];
      valid_b <= valid[raddr_b];
    end
  end

  assign rdata_a = valid_a ? ram_a : '0;
  assign rdata_b = valid_b ? ram_b : '0;

endmodule

### design/rse_dstore.sv
// Word data store; valid bits make unwritten words read as zero.
module rse_dstore (
  input  logic               clk,
  input  logic               rst,
  input  rse_pkg::dmem_req_t req,
  output rse_pkg::word_t     rdata
);

  logic [rse_pkg::DATA_DEPTH-1:0] valid;
  logic                           valid_rd;
  rse_pkg::word_t                 ram_rd;

  rse_ram #(.WIDTH(rse_pkg::XLEN), .DEPTH(rse_pkg::DATA_DEPTH)) u_ram (
    .clk   (clk),
    .wen   (req.wen),
    .waddr (req.addr),
    .wdata (req.wdata),
    .ren   (req.ren),
    .raddr (req.addr),
    .rdata (ram_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.wen) begin
      valid[req.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ren) begin
      valid_rd <= valid[req.addr];
    end
  end

  assign rdata = valid_rd ? ram_rd : '0;

endmodule

### design/rv32i_subset_execute.sv
// Execute block for ADD, SUB, AND, OR, ADDI, LW, SW, BEQ, BNE and JAL plus a
// data-word preload command. It takes one item per clock and returns one
// result per item, in order: stage 1 reads the register file (RAM,
// registered read), stage 2 executes, updates the program counter and
// accesses the data store (RAM, registered read), stage 3 is the result
// register, where load data is merged and the register write-back happens.
// Results of older items are forwarded to younger ones, so back-to-back
// dependent items need no bubbles. A stalled result register holds the
// pipeline behind it, but empty stages still take new items. Reset clears
// registers and data store at once through per-entry valid bits; there is
// no clearing pass.
module rv32i_subset_execute (
  input logic      clk,
  input logic      rst,
  rse_in_if.sink   cmd,
  rse_out_if.source res
);

  // Pipeline control
  logic x_adv;
  logic s1_adv;
  logic accept;

  // Stage 1: register read
  logic           s1_valid;
  rse_pkg::in_t   s1;
  logic           s1_a_ok;
  logic           s1_b_ok;
  rse_pkg::word_t s1_a_fwd;
  rse_pkg::word_t s1_b_fwd;
  rse_pkg::word_t s1_a_res;
  rse_pkg::word_t s1_b_res;
  logic           hit_a1;
  logic           hit_b1;

  // Stage 2: execute
  logic           s2_valid;
  rse_pkg::in_t   s2;
  rse_pkg::word_t s2_a;
  rse_pkg::word_t s2_b;
  logic           hit_a2;
  logic           hit_b2;
  rse_pkg::word_t op_a;
  rse_pkg::word_t op_b;

  rse_pkg::word_t pc;

  // Execute results
  rse_pkg::word_t     ex_next_pc;
  logic               ex_wr;
  rse_pkg::word_t     ex_value;
  logic               ex_load;
  logic               ex_taken;
  logic               ex_fault;
  rse_pkg::dmem_req_t ex_mem;
  rse_pkg::dmem_req_t dreq;
  rse_pkg::word_t     pc_plus4;
  rse_pkg::word_t     target;
  rse_pkg::word_t     mem_addr;
  logic               mem_in;
  logic               pre_in;

  // Stage 3: result register
  logic              s3_valid;
  rse_pkg::word_t    s3_next_pc;
  logic              s3_wr;
  rse_pkg::reg_idx_t s3_idx;
  rse_pkg::word_t    s3_value;
  logic              s3_load;
  logic              s3_taken;
  logic              s3_fault;

  rse_pkg::word_t rf_a;
  rse_pkg::word_t rf_b;
  rse_pkg::word_t dm_rdata;
  rse_pkg::wb_t   wb;

  // Handshake: a stage moves when the one after it is empty or moving
  assign x_adv     = !s3_valid || res.ready;
  assign s1_adv    = !s2_valid || x_adv;
  assign cmd.ready = !s1_valid || s1_adv;
  assign accept    = cmd.valid && cmd.ready;

  // Write-back from the result register, repeated harmlessly while stalled
  assign wb.en    = s3_valid && s3_wr;
  assign wb.idx   = s3_idx;
  assign wb.value = s3_load ? dm_rdata : s3_value;

  rse_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .wb      (wb),
    .ren     (accept),
    .raddr_a (cmd.data.src_reg_a),
    .raddr_b (cmd.data.src_reg_b),
    .rdata_a (rf_a),
    .rdata_b (rf_b)
  );

  rse_dstore u_dstore (
    .clk   (clk),
    .rst   (rst),
    .req   (dreq),
    .rdata (dm_rdata)
  );

  // Stage 1 operand resolution: write-back snoop over earlier snoop over RAM
  assign hit_a1   = wb.en && (wb.idx == s1.src_reg_a);
  assign hit_b1   = wb.en && (wb.idx == s1.src_reg_b);
  assign s1_a_res = hit_a1 ? wb.value : (s1_a_ok ? s1_a_fwd : rf_a);
  assign s1_b_res = hit_b1 ? wb.value : (s1_b_ok ? s1_b_fwd : rf_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage 1 payload; a write at the read edge is missed by the RAM
  always_ff @(posedge clk) begin
    if (accept) begin
      s1       <= cmd.data;
      s1_a_ok  <= wb.en && (wb.idx == cmd.data.src_reg_a);
      s1_b_ok  <= wb.en && (wb.idx == cmd.data.src_reg_b);
      s1_a_fwd <= wb.value;
      s1_b_fwd <= wb.value;
    end else begin
      if (hit_a1) begin
        s1_a_ok  <= 1'b1;
        s1_a_fwd <= wb.value;
      end
      if (hit_b1) begin
        s1_b_ok  <= 1'b1;
        s1_b_fwd <= wb.value;
      end
    end
  end

  // Stage 2 operands: the result register forwards over the held value
  assign hit_a2 = wb.en && (wb.idx == s2.src_reg_a);
  assign hit_b2 = wb.en && (wb.idx == s2.src_reg_b);
  assign op_a   = hit_a2 ? wb.value : s2_a;
  assign op_b   = hit_b2 ? wb.value : s2_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      s2   <= s1;
      s2_a <= s1_a_res;
      s2_b <= s1_b_res;
    end else begin
      s2_a <= op_a;
      s2_b <= op_b;
    end
  end

  // Execute
  assign pc_plus4 = pc + rse_pkg::PC_STEP;
  assign target   = pc + rse_pkg::word_t'(s2.immediate) + rse_pkg::PC_STEP;
  assign mem_addr = op_a + rse_pkg::word_t'(s2.immediate);
  assign mem_in   = mem_addr < rse_pkg::DATA_LIMIT;
  assign pre_in   = rse_pkg::word_t'(s2.preload_address) < rse_pkg::DATA_LIMIT;

  always_comb begin
    ex_next_pc   = pc_plus4;
    ex_wr        = 1'b0;
    ex_value     = '0;
    ex_load      = 1'b0;
    ex_taken     = 1'b0;
    ex_fault     = 1'b0;
    ex_mem.wen   = 1'b0;
    ex_mem.ren   = 1'b0;
    ex_mem.addr  = mem_addr[rse_pkg::DATA_AW-1:0];
    ex_mem.wdata = op_b;
    if (s2.command == rse_pkg::CMD_PRELOAD) begin
      ex_next_pc = pc;
      if (pre_in) begin
        ex_mem.wen   = 1'b1;
        ex_mem.addr  = rse_pkg::DATA_AW'(s2.preload_address);
        ex_mem.wdata = rse_pkg::word_t'(s2.preload_value);
      end else begin
        ex_fault = 1'b1;
      end
    end else begin
      case (s2.opcode)
        rse_pkg::OP_ADD: begin
          ex_wr    = 1'b1;
          ex_value = op_a + op_b;
        end
        rse_pkg::OP_SUB: begin
          ex_wr    = 1'b1;
          ex_value = op_a - op_b;
        end
        rse_pkg::OP_AND: begin
          ex_wr    = 1'b1;
          ex_value = op_a & op_b;
        end
        rse_pkg::OP_OR: begin
          ex_wr    = 1'b1;
          ex_value = op_a | op_b;
        end
        rse_pkg::OP_ADDI: begin
          ex_wr    = 1'b1;
          ex_value = mem_addr;
        end
        rse_pkg::OP_LW: begin
          ex_wr = 1'b1;
          if (mem_in) begin
            ex_mem.ren = 1'b1;
            ex_load    = 1'b1;
          end else begin
            ex_fault = 1'b1;
          end
        end
        rse_pkg::OP_SW: begin
          if (mem_in) begin
            ex_mem.wen = 1'b1;
          end else begin
            ex_fault = 1'b1;
          end
        end
        rse_pkg::OP_BEQ: begin
          if (op_a == op_b) begin
            ex_taken   = 1'b1;
            ex_next_pc = target;
          end
        end
        rse_pkg::OP_BNE: begin
          if (op_a != op_b) begin
            ex_taken   = 1'b1;
            ex_next_pc = target;
          end
        end
        rse_pkg::OP_JAL: begin
          ex_wr      = 1'b1;
          ex_value   = pc_plus4;
          ex_taken   = 1'b1;
          ex_next_pc = target;
        end
        default: begin
        end
      endcase
      // x0 is never written
      if (s2.dest_reg == '0) begin
        ex_wr   = 1'b0;
        ex_load = 1'b0;
      end
    end
  end

  // Data store side effects happen once, as the item leaves execute
  always_comb begin
    dreq     = ex_mem;
    dreq.wen = ex_mem.wen && s2_valid && x_adv;
    dreq.ren = ex_mem.ren && s2_valid && x_adv;
  end

  // Program counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else if (s2_valid && x_adv) begin
      pc <= ex_next_pc;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (x_adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && x_adv) begin
      s3_next_pc <= ex_next_pc;
      s3_wr      <= ex_wr;
      s3_idx     <= ex_wr ? s2.dest_reg : '0;
      s3_value   <= (ex_wr && !ex_load) ? ex_value : '0;
      s3_load    <= ex_load;
      s3_taken   <= ex_taken;
      s3_fault   <= ex_fault;
    end
  end

  assign res.valid              = s3_valid;
  assign res.data.next_pc       = s3_next_pc;
  assign res.data.reg_written   = s3_wr;
  assign res.data.written_index = s3_idx;
  assign res.data.written_value = wb.value;
  assign res.data.branch_taken  = s3_taken;
  assign res.data.address_fault = s3_fault;

endmodule

### design/rse_checker.sv
`include "rv32i_subset_execute_macros.svh"

// Port-level checks of the execute block.
module rse_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_ready,
  input logic          res_valid,
  input logic          res_ready,
  input rse_pkg::out_t res_data
);

  // a waiting result holds still
  `RSE_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_data), "result changed while stalled")

  // an empty result register never blocks the input
  `RSE_ASSERT_IMP(a_ready_when_empty, !res_valid, cmd_ready, "input blocked with empty output")

  // an accepted item reaches the output through stages 1 and 2 while the result side keeps up
  `RSE_ASSERT_IMP(a_latency, $past(cmd_valid && cmd_ready, 3) && $past(res_ready, 1) && $past(res_ready, 2) && !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3), res_valid, "result missing three cycles after accept")

  // x0 is never reported as written
  `RSE_ASSERT_IMP(a_no_x0_write, res_valid && res_data.reg_written, res_data.written_index != '0, "write to x0 reported")

endmodule

bind rv32i_subset_execute rse_checker u_rse_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_data  (res.data)
);
